/* design/ure_pkg.sv */
package ure_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_COUNT    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER_US      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ECHO_TIMEOUT_US = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ECHO_CLAMP_US   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_US       = 3'd4;

  localparam int SumW     = 20;
  localparam int FracW    = 4;
  localparam int DivW     = SumW + FracW;
  localparam int DivCntW  = $clog2(DivW);
  localparam int TickW    = 17;
  localparam int DistW    = 15;
  localparam int UsPerCmW = 6;

  localparam logic [UsPerCmW-1:0] US_PER_CM = 6'd58;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic             trigger_out;
    logic             busy_res;
    logic             distance_valid;
    logic [DistW-1:0] distance_q4;
  } out_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_TRIG   = 5'b00010,
    PH_WAIT   = 5'b00100,
    PH_MEAS   = 5'b01000,
    PH_SETTLE = 5'b10000
  } phase_e;

endpackage

/* design/ultrasonic_echo_ranger_unit.sv */
// Ultrasonic echo ranger.
// The input channel carries one transaction per microsecond tick: a start
// request and the sampled echo level. Every input transaction yields exactly
// one output transaction holding the trigger pin level, the busy flag, a
// distance-valid flag and the last distance in centimetres with four fraction
// bits.
// Ordinary ticks can be accepted one per cycle while the input is not stalled.
// The tick that completes a sequence starts a restoring divider that retires
// one quotient bit per cycle; that tick's result appears once the divider is
// done, and no input is taken while the divider runs.
// A finished result waits in the output register; input is still accepted
// while it drains, and input stalls only when that register is held by a
// stalled receiver or the divider is running.
// Reset loads the default register values, returns the sequencer to idle and
// clears the stored distance. Registers are written through the plain write
// port, and should only be changed while the block is idle.
module ultrasonic_echo_ranger_unit #(
  parameter int MAX_SAMPLES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ure_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ure_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ure_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ure_pkg::out_t                out_data_o
);
  import ure_pkg::*;

  localparam int SdW  = $clog2(MAX_SAMPLES + 1);
  localparam int CntW = (SdW > 5) ? SdW : 5;
  localparam int DvW  = SdW + UsPerCmW;

  logic [4:0]  sample_count_q;
  logic [7:0]  trigger_us_q;
  logic [15:0] echo_timeout_q;
  logic [15:0] echo_clamp_q;
  logic [15:0] settle_us_q;

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [15:0]      width_q, width_d;
  logic [SdW-1:0]   sd_q, sd_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic             prev_echo_q, prev_echo_d;
  logic [DistW-1:0] last_dist_q;

  logic             div_busy_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [DivW-1:0]  quo_q;
  logic [DvW-1:0]   rem_q, dvs_q;
  logic [DvW:0]     rem_sh;
  logic             div_ge;
  logic [DvW-1:0]   rem_nx;
  logic [DivW-1:0]  quo_nx;
  logic             div_done;
  logic [DistW-1:0] dist_sat;

  out_t out_q;
  logic out_valid_q;

  logic            in_fire, out_fire;
  logic            rise, sample_end, leave, finish;
  logic [15:0]     sample_val;
  logic [SumW:0]   sum_add;
  logic [TickW-1:0] tick_inc;
  logic [7:0]      eff_trig;
  logic [CntW-1:0] eff_samples;

  assign in_stall_o  = div_busy_q | (out_valid_q & out_stall_i);
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_fire    = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign eff_trig = (trigger_us_q == 8'd0) ? 8'd1 : trigger_us_q;

  always_comb begin
    if (sample_count_q == 5'd0) begin
      eff_samples = CntW'(1);
    end else if (CntW'(sample_count_q) > CntW'(MAX_SAMPLES)) begin
      eff_samples = CntW'(MAX_SAMPLES);
    end else begin
      eff_samples = CntW'(sample_count_q);
    end
  end

  assign rise     = in_data_i.echo_level & ~prev_echo_q;
  assign tick_inc = tick_q + TickW'(1);

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    width_d     = width_q;
    sd_d        = sd_q;
    sum_d       = sum_q;
    prev_echo_d = prev_echo_q;
    sample_end  = 1'b0;
    sample_val  = 16'd0;
    leave       = 1'b0;
    finish      = 1'b0;
    sum_add     = '0;
    if (in_fire) begin
      prev_echo_d = in_data_i.echo_level;
      case (phase_q)
        PH_IDLE: begin
          if (in_data_i.start_req) begin
            sd_d    = '0;
            sum_d   = '0;
            width_d = '0;
            phase_d = PH_TRIG;
            tick_d  = TickW'(1);
          end
        end
        PH_TRIG: begin
          if (tick_q >= TickW'(eff_trig)) begin
            phase_d = PH_WAIT;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_WAIT: begin
          if (rise) begin
            phase_d = PH_MEAS;
            width_d = (echo_clamp_q == 16'd0) ? 16'd0 : 16'd1;
          end else begin
            tick_d = tick_inc;
            if (tick_inc > TickW'(echo_timeout_q)) begin
              sample_end = 1'b1;
              sample_val = echo_clamp_q;
            end
          end
        end
        PH_MEAS: begin
          if (!in_data_i.echo_level) begin
            sample_end = 1'b1;
            sample_val = (width_q < echo_clamp_q) ? width_q : echo_clamp_q;
          end else if (width_q < echo_clamp_q) begin
            width_d = width_q + 16'd1;
          end
        end
        PH_SETTLE: begin
          if (tick_q >= TickW'(settle_us_q)) begin
            leave = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase

      if (sample_end) begin
        sum_add = {1'b0, sum_q} + (SumW + 1)'(sample_val);
        sum_d   = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
        sd_d    = sd_q + SdW'(1);
        if (settle_us_q == 16'd0) begin
          leave = 1'b1;
        end else begin
          phase_d = PH_SETTLE;
          tick_d  = TickW'(1);
        end
      end

      if (leave) begin
        if (CntW'(sd_d) >= eff_samples) begin
          finish  = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_TRIG;
          tick_d  = TickW'(1);
        end
      end
    end
  end

  assign rem_sh   = {rem_q, quo_q[DivW-1]};
  assign div_ge   = rem_sh >= {1'b0, dvs_q};
  assign rem_nx   = div_ge ? DvW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvW-1:0];
  assign quo_nx   = {quo_q[DivW-2:0], div_ge};
  assign div_done = div_busy_q && (div_cnt_q == DivCntW'(DivW - 1));
  assign dist_sat = (quo_nx[DivW-1:DistW] != '0) ? {DistW{1'b1}} : quo_nx[DistW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= 5'd2;
      trigger_us_q   <= 8'd10;
      echo_timeout_q <= 16'd60000;
      echo_clamp_q   <= 16'd11650;
      settle_us_q    <= 16'd60000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_COUNT:    sample_count_q <= cfg_data_i[4:0];
        CFG_TRIGGER_US:      trigger_us_q   <= cfg_data_i[7:0];
        CFG_ECHO_TIMEOUT_US: echo_timeout_q <= cfg_data_i;
        CFG_ECHO_CLAMP_US:   echo_clamp_q   <= cfg_data_i;
        CFG_SETTLE_US:       settle_us_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      width_q     <= '0;
      sd_q        <= '0;
      sum_q       <= '0;
      prev_echo_q <= 1'b0;
      last_dist_q <= '0;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      width_q     <= width_d;
      sd_q        <= sd_d;
      sum_q       <= sum_d;
      prev_echo_q <= prev_echo_d;
      if (finish) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= '0;
      end else if (div_done) begin
        div_busy_q  <= 1'b0;
        last_dist_q <= dist_sat;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      if ((in_fire && !finish) || div_done) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      quo_q <= {sum_d, {FracW{1'b0}}};
      rem_q <= '0;
      dvs_q <= DvW'(sd_d) * DvW'(US_PER_CM);
    end else if (div_busy_q) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end
    if (in_fire && !finish) begin
      out_q.trigger_out    <= (phase_d == PH_TRIG);
      out_q.busy_res       <= (phase_d != PH_IDLE);
      out_q.distance_valid <= 1'b0;
      out_q.distance_q4    <= last_dist_q;
    end else if (div_done) begin
      out_q.trigger_out    <= 1'b0;
      out_q.busy_res       <= 1'b0;
      out_q.distance_valid <= 1'b1;
      out_q.distance_q4    <= dist_sat;
    end
  end

  a_stall_while_dividing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> in_stall_o)
    else $error("input accepted while the divider is running");

  a_finish_starts_divider : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && finish) |=> (div_busy_q && !out_valid_q))
    else $error("sequence end did not start the divider");

  a_valid_result_is_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.distance_valid) |->
      (!out_data_o.busy_res && !out_data_o.trigger_out))
    else $error("distance presented while busy");

  a_divider_ends_in_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |=> (out_valid_q && out_q.distance_valid && !div_busy_q))
    else $error("divider finished without presenting a distance");

endmodule

/* dv/ultrasonic_echo_ranger_checker.sv */
`timescale 1ns / 1ps
module ultrasonic_echo_ranger_checker #(
  parameter int MAX_SAMPLES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ure_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ure_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  ure_pkg::in_t                 in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  ure_pkg::out_t                out_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output logic                         seq_active_o
);
  import ure_pkg::*;

  localparam longint unsigned DistMax = (64'd1 << DistW) - 1;

  logic [4:0]       smp_cfg;
  logic [7:0]       trig_cfg;
  logic [15:0]      tmo_cfg;
  logic [15:0]      clamp_cfg;
  logic [15:0]      settle_cfg;

  phase_e           phase_q;
  logic [TickW-1:0] tick_q;
  logic [15:0]      width_q;
  logic [4:0]       done_q;
  logic [SumW-1:0]  sum_q;
  logic             echo_q;
  logic [DistW-1:0] dist_q;

  out_t             expected_q[$];
  out_t             want;
  int unsigned      fails;
  int unsigned      pending_q;
  int unsigned      results_seen;

  assign fail_count_o = fails;
  assign pending_o    = pending_q;
  assign seq_active_o = (phase_q != PH_IDLE);

  task automatic report_mismatch(input string msg);
    if (fails < 200) begin
      $display("%0t: transaction %0d: %s", $realtime, results_seen, msg);
    end
    fails++;
  endtask

  function automatic int unsigned samples_needed();
    if (smp_cfg == '0) begin
      return 1;
    end
    if (smp_cfg > MAX_SAMPLES) begin
      return MAX_SAMPLES;
    end
    return 32'(smp_cfg);
  endfunction

  function automatic bit finish_or_retrigger();
    longint unsigned num;
    longint unsigned den;
    longint unsigned quot;
    if (done_q >= samples_needed()) begin
      num = 64'(sum_q);
      num = num * 16;
      den = 64'(done_q);
      den = den * US_PER_CM;
      quot = num / den;
      dist_q = (quot > DistMax) ? '1 : quot[DistW-1:0];
      phase_q = PH_IDLE;
      return 1'b1;
    end
    phase_q = PH_TRIG;
    tick_q = TickW'(1);
    return 1'b0;
  endfunction

  function automatic bit close_sample(input logic [15:0] width_in);
    logic [SumW:0] total;
    total = {1'b0, sum_q} + (SumW + 1)'(width_in);
    sum_q = total[SumW] ? '1 : total[SumW-1:0];
    done_q++;
    if (settle_cfg == '0) begin
      return finish_or_retrigger();
    end
    phase_q = PH_SETTLE;
    tick_q = TickW'(1);
    return 1'b0;
  endfunction

  function automatic out_t predict_tick(input in_t item);
    logic rise;
    bit   fresh;
    out_t res;
    rise = item.echo_level && !echo_q;
    fresh = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (item.start_req) begin
          done_q = '0;
          sum_q = '0;
          width_q = '0;
          phase_q = PH_TRIG;
          tick_q = TickW'(1);
        end
      end
      PH_TRIG: begin
        if (tick_q >= ((trig_cfg == '0) ? 8'd1 : trig_cfg)) begin
          phase_q = PH_WAIT;
          tick_q = '0;
        end else begin
          tick_q++;
        end
      end
      PH_WAIT: begin
        if (rise) begin
          phase_q = PH_MEAS;
          width_q = (clamp_cfg == '0) ? 16'd0 : 16'd1;
        end else begin
          tick_q = tick_q + 1'b1;
          if (tick_q > tmo_cfg) begin
            fresh = close_sample(clamp_cfg);
          end
        end
      end
      PH_MEAS: begin
        if (!item.echo_level) begin
          fresh = close_sample((width_q < clamp_cfg) ? width_q : clamp_cfg);
        end else if (width_q < clamp_cfg) begin
          width_q++;
        end
      end
      PH_SETTLE: begin
        if (tick_q >= settle_cfg) begin
          fresh = finish_or_retrigger();
        end else begin
          tick_q++;
        end
      end
      default: begin
        phase_q = PH_IDLE;
      end
    endcase
    echo_q = item.echo_level;
    res.trigger_out    = (phase_q == PH_TRIG);
    res.busy_res       = (phase_q != PH_IDLE);
    res.distance_valid = fresh;
    res.distance_q4    = dist_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_cfg      = 5'd2;
      trig_cfg     = 8'd10;
      tmo_cfg      = 16'd60000;
      clamp_cfg    = 16'd11650;
      settle_cfg   = 16'd60000;
      phase_q      = PH_IDLE;
      tick_q       = '0;
      width_q      = '0;
      done_q       = '0;
      sum_q        = '0;
      echo_q       = 1'b0;
      dist_q       = '0;
      fails        = 0;
      results_seen = 0;
      expected_q.delete();
      pending_q    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("output transaction with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.trigger_out !== want.trigger_out) begin
            report_mismatch($sformatf("trigger_out %b, expected %b",
                                      out_data_i.trigger_out, want.trigger_out));
          end
          if (out_data_i.busy_res !== want.busy_res) begin
            report_mismatch($sformatf("busy_res %b, expected %b",
                                      out_data_i.busy_res, want.busy_res));
          end
          if (out_data_i.distance_valid !== want.distance_valid) begin
            report_mismatch($sformatf("distance_valid %b, expected %b",
                                      out_data_i.distance_valid, want.distance_valid));
          end
          if (out_data_i.distance_q4 !== want.distance_q4) begin
            report_mismatch($sformatf("distance_q4 %0d, expected %0d",
                                      out_data_i.distance_q4, want.distance_q4));
          end
        end
        results_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_COUNT:    smp_cfg    = cfg_data_i[4:0];
          CFG_TRIGGER_US:      trig_cfg   = cfg_data_i[7:0];
          CFG_ECHO_TIMEOUT_US: tmo_cfg    = cfg_data_i[15:0];
          CFG_ECHO_CLAMP_US:   clamp_cfg  = cfg_data_i[15:0];
          CFG_SETTLE_US:       settle_cfg = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_tick(in_data_i));
      end
      pending_q = expected_q.size();
    end
  end

endmodule

/* dv/ultrasonic_echo_ranger_unit_tb.sv */
`timescale 1ns / 1ps
module ultrasonic_echo_ranger_unit_tb;
  import ure_pkg::*;

  localparam int          MaxSamples = 16;
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned BurstTicks = 70;

  localparam logic [19:0] DirStart = 20'b0110_0000_0000_0000_0001;
  localparam logic [19:0] DirEcho  = 20'b0111_1011_1100_0000_0000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CFG_SAMPLE_COUNT;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;

  int unsigned         mismatches;
  int unsigned         outstanding;
  logic                seq_active;

  bit                  gaps_on      = 1'b1;
  bit                  stall_on     = 1'b1;
  bit                  hold_pending = 1'b0;
  int unsigned         cycle_count  = 0;

  int unsigned         trig_len;
  int unsigned         tmo_len;
  int unsigned         clamp_len;
  int unsigned         settle_len;

  ultrasonic_echo_ranger_unit #(
    .MAX_SAMPLES(MaxSamples)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  ultrasonic_echo_ranger_checker #(
    .MAX_SAMPLES(MaxSamples)
  ) u_ranging_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(mismatches),
    .pending_o   (outstanding),
    .seq_active_o(seq_active)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // A long hold-off, when requested, lets the output register fill so that the
  // block has to stall its input.
  initial begin : receiver
    int unsigned len;
    logic        level;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        level = 1'b1;
        len = HoldCycles;
      end else if (!stall_on || $urandom_range(0, 9) < 7) begin
        level = 1'b0;
        len = $urandom_range(1, 8);
      end else begin
        level = 1'b1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      @(negedge clk_i);
      out_stall_i <= level;
      repeat (len - 1) @(negedge clk_i);
    end
  end

  task automatic send_tick(input logic start, input logic echo);
    int unsigned gap;
    int unsigned roll;
    in_t         item;
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 94) begin
        gap = $urandom_range(8, 40);
      end else if (roll >= 65) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item.start_req  = start;
    item.echo_level = echo;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_regs(input int unsigned smp, trig, tmo, clamp, settle);
    logic [CfgDataW-1:0] junk;
    logic [CfgDataW-1:0] smp_word;
    logic [CfgDataW-1:0] trig_word;
    junk = CfgDataW'($urandom);
    smp_word = CfgDataW'(smp);
    trig_word = CfgDataW'(trig);
    if ($urandom_range(0, 1) == 1) begin
      smp_word[CfgDataW-1:5] = junk[CfgDataW-1:5];
      trig_word[CfgDataW-1:8] = junk[CfgDataW-1:8];
    end
    write_reg(CFG_SAMPLE_COUNT, smp_word);
    write_reg(CFG_TRIGGER_US, trig_word);
    write_reg(CFG_ECHO_TIMEOUT_US, CfgDataW'(tmo));
    write_reg(CFG_ECHO_CLAMP_US, CfgDataW'(clamp));
    write_reg(CFG_SETTLE_US, CfgDataW'(settle));
    trig_len   = (trig == 0) ? 1 : trig;
    tmo_len    = tmo;
    clamp_len  = clamp;
    settle_len = settle;
  endtask

  // Runs the sequence to completion, then waits for every transaction to drain
  // and for the divider to finish before the registers may be touched.
  task automatic quiesce();
    while (seq_active) begin
      send_tick(1'b0, 1'b0);
    end
    in_valid_i <= 1'b0;
    wait (outstanding == 0);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic run_ticks(input int unsigned n);
    int unsigned sent;
    int unsigned len;
    int unsigned lo_max;
    int unsigned hi_max;
    logic        level;
    logic        start;
    sent = 0;
    level = 1'b0;
    lo_max = trig_len + tmo_len + settle_len + 4;
    hi_max = clamp_len + 3;
    if (lo_max > 300) begin
      lo_max = 300;
    end
    if (hi_max > 300) begin
      hi_max = 300;
    end
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        len = 1;
      end else begin
        len = $urandom_range(1, level ? hi_max : lo_max);
      end
      for (int i = 0; i < len && sent < n; i++) begin
        start = (i == 0 && !level && $urandom_range(0, 2) == 0) ||
                ($urandom_range(0, 31) == 0);
        send_tick(start, level);
        sent++;
      end
      level = ~level;
    end
  endtask

  initial begin : stimulus
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    program_regs(2, 2, 3, 3, 1);
    for (int i = 0; i < 20; i++) begin
      send_tick(DirStart[19-i], DirEcho[19-i]);
    end
    quiesce();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: program_regs(1, 1, 1, 1, 0);
        1: program_regs(16, 3, 20, 30, 2);
        2: program_regs(0, 0, 5, 0, 1);
        3: program_regs(31, 2, 8, 12, 0);
        4: program_regs(1, 255, 6, 20, 3);
        default: begin
          program_regs($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 40),
                       $urandom_range(1, 60), $urandom_range(0, 4));
        end
      endcase
      if (ph == 3) begin
        run_ticks(50);
        hold_pending = 1'b1;
        run_ticks(BurstTicks);
      end else begin
        run_ticks((ph == 4) ? 250 : BurstTicks);
      end
      quiesce();
    end

    // Wide timeout and clamp values, then timeouts with settling, run back to back.
    gaps_on = 1'b0;
    stall_on = 1'b0;
    program_regs(1, 2, 65535, 65535, 0);
    send_tick(1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'b0);
    repeat (150) send_tick(1'b0, 1'b1);
    quiesce();
    program_regs(2, 1, 40, 65535, 20);
    send_tick(1'b1, 1'b0);
    quiesce();

    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
